### hw/rtl/tfc_pkg.sv
// Shared types, codes and constants of the test frame checker.
`default_nettype none

package tfc_pkg;

  // Default sizing of the checker.
  localparam int unsigned SeqDepthDef = 256;
  localparam int unsigned MinFrameDef = 60;
  localparam int unsigned MaxFrameDef = 1500;

  // Frame layout.
  localparam logic [10:0] PosTypeHi  = 11'd12;
  localparam logic [10:0] PosTypeLo  = 11'd13;
  localparam logic [10:0] PosCheck   = 11'd14;
  localparam logic [10:0] PosLenHi   = 11'd15;
  localparam logic [10:0] PosLenLo   = 11'd16;
  localparam logic [10:0] PosSeqFirst = 11'd17;
  localparam logic [10:0] PosSeqLast = 11'd21 - 11'd1;
  localparam logic [10:0] CountSat   = 11'd2047;

  localparam logic [15:0] FrameType = 16'h0800;
  localparam logic [7:0]  TailHi    = 8'hBE;
  localparam logic [7:0]  TailLo    = 8'hAF;

  // Configuration register indexes.
  localparam logic RegCheckMode = 1'b0;
  localparam logic RegSeqLimit  = 1'b1;

  localparam logic [8:0] SeqLimitRst = 9'd256;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_FULL   = 2'd1,
    MODE_LENGTH = 2'd2
  } check_mode_e;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_READ = 1'b1
  } operation_e;

  typedef enum logic [1:0] {
    VERDICT_GOOD     = 2'd0,
    VERDICT_FILTERED = 2'd1,
    VERDICT_ERROR    = 2'd2,
    VERDICT_READ     = 2'd3
  } verdict_e;

  // Outcome of a frame or a histogram read, as it travels to the result stage.
  typedef struct packed {
    logic        is_read;
    logic        filtered;
    logic        chk_err;
    logic        in_range;
    logic [31:0] seq;
    logic [10:0] size;
  } frame_info_t;

endpackage

`default_nettype wire

### hw/rtl/tfc_parser.sv
// Frame header parser and per-frame filter and check decisions.
`default_nettype none

module tfc_parser
  import tfc_pkg::*;
#(
  parameter int unsigned SEQ_DEPTH = SeqDepthDef,
  parameter int unsigned MIN_FRAME = MinFrameDef,
  parameter int unsigned MAX_FRAME = MaxFrameDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        byte_en_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic [1:0]  check_mode_i,
  input  wire logic [8:0]  seq_limit_i,
  output frame_info_t      info_o
);

  logic [10:0] pos_q, pos_d;
  logic [7:0]  sum_q, sum_d;
  logic [15:0] type_q, type_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  chk_q, chk_d;
  logic [31:0] seq_q, seq_d;
  logic [7:0]  prev_q;
  logic        over_q, over_d;
  logic        size_bad;
  logic        len_bad;

  always_comb begin
    type_d = type_q;
    len_d  = len_q;
    chk_d  = chk_q;
    seq_d  = seq_q;
    if (pos_q == PosTypeHi || pos_q == PosTypeLo) begin
      type_d = {type_q[7:0], rx_byte_i};
    end else if (pos_q == PosCheck) begin
      chk_d = rx_byte_i;
    end else if (pos_q == PosLenHi || pos_q == PosLenLo) begin
      len_d = {len_q[7:0], rx_byte_i};
    end else if (pos_q >= PosSeqFirst && pos_q <= PosSeqLast) begin
      seq_d = {seq_q[23:0], rx_byte_i};
    end
    sum_d  = (pos_q == PosCheck) ? sum_q : sum_q + rx_byte_i;
    // The count sticks at its ceiling and the frame is marked oversize.
    over_d = over_q;
    pos_d  = pos_q;
    if (pos_q == CountSat) begin
      over_d = 1'b1;
    end else begin
      pos_d = pos_q + 11'd1;
    end
  end

  always_comb begin
    size_bad = over_d || (pos_d < 11'(MIN_FRAME)) || (pos_d > 11'(MAX_FRAME));
    len_bad  = len_d != {5'd0, pos_d};
    info_o.is_read  = 1'b0;
    info_o.filtered = (type_d != FrameType) || size_bad ||
                      (prev_q != TailHi) || (rx_byte_i != TailLo);
    unique case (check_mode_i)
      MODE_FULL:   info_o.chk_err = len_bad || (sum_d != chk_d);
      MODE_LENGTH: info_o.chk_err = len_bad;
      default:     info_o.chk_err = 1'b0;
    endcase
    info_o.in_range = (seq_d < {23'd0, seq_limit_i}) && (seq_d < 32'(SEQ_DEPTH));
    info_o.seq      = seq_d;
    info_o.size     = pos_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      sum_q  <= '0;
      type_q <= '0;
      len_q  <= '0;
      chk_q  <= '0;
      seq_q  <= '0;
      prev_q <= '0;
      over_q <= 1'b0;
    end else if (byte_en_i) begin
      if (last_byte_i) begin
        pos_q  <= '0;
        sum_q  <= '0;
        type_q <= '0;
        len_q  <= '0;
        chk_q  <= '0;
        seq_q  <= '0;
        prev_q <= '0;
        over_q <= 1'b0;
      end else begin
        pos_q  <= pos_d;
        sum_q  <= sum_d;
        type_q <= type_d;
        len_q  <= len_d;
        chk_q  <= chk_d;
        seq_q  <= seq_d;
        prev_q <= rx_byte_i;
        over_q <= over_d;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/tfc_hist.sv
// Sequence id histogram memory with clearing pass and write forwarding.
`default_nettype none

module tfc_hist
  import tfc_pkg::*;
#(
  parameter int unsigned SEQ_DEPTH = SeqDepthDef,
  localparam int unsigned AW = $clog2(SEQ_DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          rd_en_i,
  input  wire logic [AW-1:0] rd_addr_i,
  input  wire logic          inc_i,
  output logic [31:0]        hits_o,
  output logic               clearing_o
);

  logic [31:0]   mem [SEQ_DEPTH];
  logic [31:0]   rd_data_q;
  logic [AW-1:0] addr_q;
  logic          fwd_valid_q;
  logic [AW-1:0] fwd_addr_q;
  logic [31:0]   fwd_data_q;
  logic          clr_q;
  logic [AW-1:0] clr_cnt_q;
  logic [31:0]   inc_data;

  // A write on the edge that loaded the read sees the old entry; the
  // forwarding register supplies the new value instead.
  assign hits_o   = (fwd_valid_q && fwd_addr_q == addr_q) ? fwd_data_q : rd_data_q;
  assign inc_data = hits_o + 32'd1;
  assign clearing_o = clr_q;

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_cnt_q] <= '0;
    end else if (inc_i) begin
      mem[addr_q] <= inc_data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      addr_q     <= rd_addr_i;
      fwd_addr_q <= addr_q;
      fwd_data_q <= inc_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
    end else begin
      if (rd_en_i) begin
        fwd_valid_q <= inc_i;
      end
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(SEQ_DEPTH - 1)) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/test_frame_checker.sv
// Test frame checker top level: configuration, result stage, counters, output register.
// The accepting edge loads a request's outcome into the result stage, which passes it on to
// the output register once free; each holds one. One request per cycle when not stalled;
// the histogram port (one read, one write per cycle) sets the two-stage result path.
// Reset clears all control state and counters, then a clearing pass zeroes all SEQ_DEPTH
// histogram entries while the input is stalled; configuration writes are taken throughout.
`default_nettype none

module test_frame_checker
  import tfc_pkg::*;
#(
  parameter int unsigned SEQ_DEPTH = SeqDepthDef,
  parameter int unsigned MIN_FRAME = MinFrameDef,
  parameter int unsigned MAX_FRAME = MaxFrameDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [8:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        operation_i,
  input  wire logic [7:0]  rx_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic [7:0]  seq_index_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       verdict_o,
  output logic [31:0]      frame_seq_o,
  output logic [10:0]      frame_bytes_o,
  output logic [31:0]      seq_hits_o,
  output logic [31:0]      good_total_o,
  output logic [31:0]      error_total_o,
  output logic [31:0]      filtered_total_o,
  output logic [47:0]      good_byte_total_o
);

  localparam int unsigned AW = $clog2(SEQ_DEPTH);

  logic [1:0]    mode_q;
  logic [8:0]    limit_q;

  logic          accept;
  logic          byte_en;
  logic          s1_load;
  logic          s1_move;
  logic          out_take;
  logic          out_free;
  logic          clearing;
  frame_info_t   frame_info;
  frame_info_t   s0_info;
  frame_info_t   s1_q;
  logic          s1_valid_q;
  logic [AW+7:0] idx_ext;
  logic [AW-1:0] rd_addr;
  logic          hist_inc;
  logic [31:0]   hits;

  logic [31:0]   good_q, good_d;
  logic [31:0]   error_q, error_d;
  logic [31:0]   filt_q, filt_d;
  logic [47:0]   bytes_q, bytes_d;
  verdict_e      verdict_d;

  logic          out_valid_q;
  logic [1:0]    verdict_q;
  logic [31:0]   seq_out_q;
  logic [10:0]   size_out_q;
  logic [31:0]   hits_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NONE;
      limit_q <= SeqLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegCheckMode: mode_q  <= cfg_data_i[1:0];
        RegSeqLimit:  limit_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  assign out_take   = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || out_take;
  assign s1_move    = s1_valid_q && out_free;
  assign in_stall_o = clearing || (s1_valid_q && !s1_move);
  assign accept     = in_valid_i && !in_stall_o;
  assign byte_en    = accept && (operation_i == OP_BYTE);
  assign s1_load    = accept && ((operation_i == OP_READ) || last_byte_i);

  tfc_parser #(
    .SEQ_DEPTH (SEQ_DEPTH),
    .MIN_FRAME (MIN_FRAME),
    .MAX_FRAME (MAX_FRAME)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_en_i    (byte_en),
    .rx_byte_i    (rx_byte_i),
    .last_byte_i  (last_byte_i),
    .check_mode_i (mode_q),
    .seq_limit_i  (limit_q),
    .info_o       (frame_info)
  );

  // A histogram read goes down the same path as a frame, flagged as a read.
  assign idx_ext = (AW + 8)'(seq_index_i);

  always_comb begin
    s0_info = frame_info;
    rd_addr = frame_info.seq[AW-1:0];
    if (operation_i == OP_READ) begin
      s0_info          = '0;
      s0_info.is_read  = 1'b1;
      s0_info.in_range = idx_ext < (AW + 8)'(SEQ_DEPTH);
      rd_addr          = idx_ext[AW-1:0];
    end
  end

  assign hist_inc = s1_move && !s1_q.is_read && !s1_q.filtered && s1_q.in_range;

  tfc_hist #(
    .SEQ_DEPTH (SEQ_DEPTH)
  ) u_hist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (s1_load),
    .rd_addr_i  (rd_addr),
    .inc_i      (hist_inc),
    .hits_o     (hits),
    .clearing_o (clearing)
  );

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q <= s0_info;
    end
  end

  always_comb begin
    good_d  = good_q;
    error_d = error_q;
    filt_d  = filt_q;
    bytes_d = bytes_q;
    priority if (s1_q.is_read) begin
      verdict_d = VERDICT_READ;
    end else if (s1_q.filtered) begin
      verdict_d = VERDICT_FILTERED;
      filt_d    = filt_q + 32'd1;
    end else if (s1_q.chk_err || !s1_q.in_range) begin
      verdict_d = VERDICT_ERROR;
      error_d   = error_q + 32'd1;
    end else begin
      verdict_d = VERDICT_GOOD;
      good_d    = good_q + 32'd1;
      bytes_d   = bytes_q + {37'd0, s1_q.size};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      good_q      <= '0;
      error_q     <= '0;
      filt_q      <= '0;
      bytes_q     <= '0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
        good_q      <= good_d;
        error_q     <= error_d;
        filt_q      <= filt_d;
        bytes_q     <= bytes_d;
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      verdict_q  <= verdict_d;
      seq_out_q  <= s1_q.is_read ? 32'd0 : s1_q.seq;
      size_out_q <= s1_q.is_read ? 11'd0 : s1_q.size;
      hits_out_q <= (s1_q.is_read && s1_q.in_range) ? hits : 32'd0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign verdict_o         = verdict_q;
  assign frame_seq_o       = seq_out_q;
  assign frame_bytes_o     = size_out_q;
  assign seq_hits_o        = hits_out_q;
  assign good_total_o      = good_q;
  assign error_total_o     = error_q;
  assign filtered_total_o  = filt_q;
  assign good_byte_total_o = bytes_q;

  a_clear_no_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !s1_valid_q)
    else $error("result stage occupied during histogram clearing");

  a_frame_one_counter : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move && !s1_q.is_read) |=>
      $countones({good_q != $past(good_q), error_q != $past(error_q),
                  filt_q != $past(filt_q)}) == 1)
    else $error("frame result did not bump exactly one counter");

  a_read_keeps_counters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move && s1_q.is_read) |=>
      $stable(good_q) && $stable(error_q) && $stable(filt_q) && $stable(bytes_q))
    else $error("histogram read changed a counter");

endmodule

`default_nettype wire

### test/test_frame_checker_tb.sv
// Self-checking testbench for the test frame checker: directed frames, then random traffic.
module test_frame_checker_tb;
  import tfc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SeqDepth = 256;
  localparam int MinFrame = 60;
  localparam int MaxFrame = 1500;

  // Header layout and frame markers.
  localparam int TypeAt = 12;
  localparam int ChkAt = 14;
  localparam int LenAt = 15;
  localparam int IdFirst = 17;
  localparam int IdLast = 20;
  localparam logic [10:0] CountCap = 11'd2047;
  localparam logic [15:0] WantType = 16'h0800;
  localparam logic [7:0] TailMarkHi = 8'hBE;
  localparam logic [7:0] TailMarkLo = 8'hAF;
  localparam logic [1:0] ModeUnused = 2'd3;

  localparam int QuietLimit = 3000;
  localparam int RandomBytes = 1750;
  localparam int RandomFrames = 48;

  typedef struct packed {
    verdict_e    verdict;
    logic [31:0] frame_seq;
    logic [10:0] frame_bytes;
    logic [31:0] seq_hits;
    logic [31:0] good_total;
    logic [31:0] error_total;
    logic [31:0] filtered_total;
    logic [47:0] good_byte_total;
  } frame_result_t;

  typedef struct packed {
    logic        is_read;
    logic [1:0]  mode;
    logic [8:0]  limit;
    logic [11:0] size;
    logic [15:0] ftype;
    logic        len_ok;
    logic        sum_ok;
    logic        tail_ok;
    logic [31:0] fid;
    logic [7:0]  idx;
    logic        typed_ok;
    verdict_e    typed;
  } probe_row_t;

  localparam int NumProbes = 26;
  // Typed verdicts are the ones that follow directly from the frame's shape.
  localparam probe_row_t ProbeRows [NumProbes] = '{
    '{1'b1, MODE_NONE, 9'd256, 12'd0, 16'h0, 1'b1, 1'b1, 1'b1, 32'd0, 8'd0, 1'b1,
      VERDICT_READ},
    '{1'b1, MODE_NONE, 9'd256, 12'd0, 16'h0, 1'b1, 1'b1, 1'b1, 32'd0, 8'd255, 1'b1,
      VERDICT_READ},
    '{1'b0, MODE_NONE, 9'd256, 12'd60, WantType, 1'b1, 1'b1, 1'b1, 32'd0, 8'd0, 1'b1,
      VERDICT_GOOD},
    '{1'b0, MODE_NONE, 9'd256, 12'd1500, WantType, 1'b1, 1'b1, 1'b1, 32'd255, 8'd0, 1'b1,
      VERDICT_GOOD},
    '{1'b0, MODE_NONE, 9'd256, 12'd59, WantType, 1'b1, 1'b1, 1'b1, 32'd3, 8'd0, 1'b1,
      VERDICT_FILTERED},
    '{1'b0, MODE_NONE, 9'd256, 12'd1501, WantType, 1'b1, 1'b1, 1'b1, 32'd3, 8'd0, 1'b1,
      VERDICT_FILTERED},
    '{1'b0, MODE_NONE, 9'd256, 12'd1, WantType, 1'b1, 1'b1, 1'b1, 32'd3, 8'd0, 1'b1,
      VERDICT_FILTERED},
    '{1'b0, MODE_NONE, 9'd256, 12'd19, WantType, 1'b1, 1'b1, 1'b1, 32'h01020304, 8'd0,
      1'b1, VERDICT_FILTERED},
    '{1'b0, MODE_NONE, 9'd256, 12'd2050, WantType, 1'b1, 1'b1, 1'b1, 32'd4, 8'd0, 1'b1,
      VERDICT_FILTERED},
    '{1'b0, MODE_NONE, 9'd256, 12'd64, 16'h86DD, 1'b1, 1'b1, 1'b1, 32'd4, 8'd0, 1'b1,
      VERDICT_FILTERED},
    '{1'b0, MODE_NONE, 9'd256, 12'd64, WantType, 1'b1, 1'b1, 1'b0, 32'd4, 8'd0, 1'b1,
      VERDICT_FILTERED},
    '{1'b0, MODE_NONE, 9'd256, 12'd70, WantType, 1'b0, 1'b0, 1'b1, 32'd5, 8'd0, 1'b1,
      VERDICT_GOOD},
    '{1'b0, MODE_FULL, 9'd256, 12'd80, WantType, 1'b1, 1'b1, 1'b1, 32'd7, 8'd0, 1'b1,
      VERDICT_GOOD},
    '{1'b0, MODE_FULL, 9'd256, 12'd80, WantType, 1'b1, 1'b0, 1'b1, 32'd7, 8'd0, 1'b1,
      VERDICT_ERROR},
    '{1'b0, MODE_FULL, 9'd256, 12'd80, WantType, 1'b0, 1'b1, 1'b1, 32'd7, 8'd0, 1'b1,
      VERDICT_ERROR},
    '{1'b0, MODE_LENGTH, 9'd256, 12'd61, WantType, 1'b1, 1'b0, 1'b1, 32'd8, 8'd0, 1'b1,
      VERDICT_GOOD},
    '{1'b0, MODE_LENGTH, 9'd256, 12'd61, WantType, 1'b0, 1'b1, 1'b1, 32'd8, 8'd0, 1'b1,
      VERDICT_ERROR},
    '{1'b0, ModeUnused, 9'd256, 12'd62, WantType, 1'b0, 1'b0, 1'b1, 32'd9, 8'd0, 1'b1,
      VERDICT_GOOD},
    '{1'b0, MODE_NONE, 9'd256, 12'd60, WantType, 1'b1, 1'b1, 1'b1, 32'd256, 8'd0, 1'b1,
      VERDICT_ERROR},
    '{1'b0, MODE_NONE, 9'd1, 12'd60, WantType, 1'b1, 1'b1, 1'b1, 32'd0, 8'd0, 1'b1,
      VERDICT_GOOD},
    '{1'b0, MODE_NONE, 9'd1, 12'd60, WantType, 1'b1, 1'b1, 1'b1, 32'd1, 8'd0, 1'b1,
      VERDICT_ERROR},
    '{1'b0, MODE_NONE, 9'd511, 12'd60, WantType, 1'b1, 1'b1, 1'b1, 32'd300, 8'd0, 1'b1,
      VERDICT_ERROR},
    '{1'b0, MODE_NONE, 9'd511, 12'd60, WantType, 1'b1, 1'b1, 1'b1, 32'd255, 8'd0, 1'b1,
      VERDICT_GOOD},
    '{1'b0, MODE_NONE, 9'd0, 12'd60, WantType, 1'b1, 1'b1, 1'b1, 32'd0, 8'd0, 1'b1,
      VERDICT_ERROR},
    '{1'b0, MODE_NONE, 9'd256, 12'd60, WantType, 1'b1, 1'b1, 1'b1, 32'hFFFFFFFF, 8'd0,
      1'b1, VERDICT_ERROR},
    '{1'b1, MODE_NONE, 9'd256, 12'd0, 16'h0, 1'b1, 1'b1, 1'b1, 32'd0, 8'd0, 1'b1,
      VERDICT_READ}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [8:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        operation_i;
  logic [7:0]  rx_byte_i;
  logic        last_byte_i;
  logic [7:0]  seq_index_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  verdict_o;
  logic [31:0] frame_seq_o;
  logic [10:0] frame_bytes_o;
  logic [31:0] seq_hits_o;
  logic [31:0] good_total_o;
  logic [31:0] error_total_o;
  logic [31:0] filtered_total_o;
  logic [47:0] good_byte_total_o;

  test_frame_checker #(
    .SEQ_DEPTH(SeqDepth),
    .MIN_FRAME(MinFrame),
    .MAX_FRAME(MaxFrame)
  ) dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .operation_i,
    .rx_byte_i,
    .last_byte_i,
    .seq_index_i,
    .out_valid_o,
    .out_stall_i,
    .verdict_o,
    .frame_seq_o,
    .frame_bytes_o,
    .seq_hits_o,
    .good_total_o,
    .error_total_o,
    .filtered_total_o,
    .good_byte_total_o
  );

  // Shadow of the checker: configuration, frame in progress, histogram and totals.
  logic [1:0]  cur_mode;
  logic [8:0]  cur_limit;
  logic [10:0] frame_pos;
  logic [7:0]  frame_sum;
  logic [15:0] frame_type;
  logic [15:0] frame_len;
  logic [7:0]  frame_chk;
  logic [31:0] frame_id;
  logic [7:0]  prev_byte;
  logic        frame_overlong;
  logic [31:0] id_hits [SeqDepth];
  logic [31:0] n_good;
  logic [31:0] n_error;
  logic [31:0] n_filtered;
  logic [47:0] good_octets;

  frame_result_t pending_verdicts[$];
  logic [7:0]    wire_q[$];
  int            fail_count = 0;
  int            bytes_sent = 0;
  bit            sender_calm = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic void clear_frame_state();
    frame_pos = '0;
    frame_sum = '0;
    frame_type = '0;
    frame_len = '0;
    frame_chk = '0;
    frame_id = '0;
    prev_byte = '0;
    frame_overlong = 1'b0;
  endfunction

  function automatic void reset_shadow();
    cur_mode = MODE_NONE;
    cur_limit = SeqLimitRst;
    clear_frame_state();
    foreach (id_hits[i]) id_hits[i] = '0;
    n_good = '0;
    n_error = '0;
    n_filtered = '0;
    good_octets = '0;
  endfunction

  // Advances the shadow by one request; returns 1 when the request yields a result.
  function automatic bit judge_request(input operation_e op, input logic [7:0] b,
                                       input logic last, input logic [7:0] idx,
                                       output frame_result_t r);
    int          p;
    logic [10:0] sz;
    logic [31:0] lim;
    bit          filt;
    bit          bad;
    r = '0;
    if (op == OP_READ) begin
      r.verdict = VERDICT_READ;
      r.seq_hits = (int'(idx) < SeqDepth) ? id_hits[idx] : '0;
    end else begin
      p = int'(frame_pos);
      if (p == TypeAt || p == TypeAt + 1) frame_type = {frame_type[7:0], b};
      else if (p == ChkAt) frame_chk = b;
      else if (p == LenAt || p == LenAt + 1) frame_len = {frame_len[7:0], b};
      else if (p >= IdFirst && p <= IdLast) frame_id = {frame_id[23:0], b};
      if (p != ChkAt) frame_sum = frame_sum + b;
      if (frame_pos == CountCap) frame_overlong = 1'b1;
      else frame_pos = frame_pos + 11'd1;
      if (!last) begin
        prev_byte = b;
        return 1'b0;
      end
      sz = frame_pos;
      filt = (frame_type != WantType) || frame_overlong || (int'(sz) < MinFrame) ||
             (int'(sz) > MaxFrame) || (prev_byte != TailMarkHi) || (b != TailMarkLo);
      if (filt) begin
        n_filtered = n_filtered + 1;
        r.verdict = VERDICT_FILTERED;
      end else begin
        bad = 1'b0;
        if (cur_mode == MODE_FULL) begin
          bad = (frame_len != 16'(sz)) || (frame_sum != frame_chk);
        end else if (cur_mode == MODE_LENGTH) begin
          bad = (frame_len != 16'(sz));
        end
        lim = (int'(cur_limit) < SeqDepth) ? 32'(cur_limit) : 32'(SeqDepth);
        if (frame_id < lim) id_hits[frame_id[7:0]] = id_hits[frame_id[7:0]] + 1;
        else bad = 1'b1;
        if (bad) begin
          n_error = n_error + 1;
          r.verdict = VERDICT_ERROR;
        end else begin
          n_good = n_good + 1;
          good_octets = good_octets + 48'(sz);
          r.verdict = VERDICT_GOOD;
        end
      end
      r.frame_seq = frame_id;
      r.frame_bytes = sz;
      clear_frame_state();
    end
    r.good_total = n_good;
    r.error_total = n_error;
    r.filtered_total = n_filtered;
    r.good_byte_total = good_octets;
    return 1'b1;
  endfunction

  // Fills wire_q with one frame; raw frames keep their random bytes untouched.
  function automatic void build_frame(input int sz, input logic [15:0] ftype,
                                      input logic [15:0] flen, input logic [31:0] fid,
                                      input bit tail_ok, input bit sum_ok, input bit raw);
    logic [7:0] s;
    wire_q.delete();
    for (int i = 0; i < sz; i++) wire_q.push_back(8'($urandom));
    if (raw) return;
    for (int i = 0; i < 2; i++)
      if (TypeAt + i < sz) wire_q[TypeAt + i] = ftype[15 - 8*i -: 8];
    for (int i = 0; i < 2; i++)
      if (LenAt + i < sz) wire_q[LenAt + i] = flen[15 - 8*i -: 8];
    for (int i = 0; i < 4; i++)
      if (IdFirst + i < sz) wire_q[IdFirst + i] = fid[31 - 8*i -: 8];
    if (sz >= 2) begin
      wire_q[sz-2] = TailMarkHi;
      wire_q[sz-1] = TailMarkLo;
      if (!tail_ok) begin
        if ($urandom_range(0, 1) == 0) wire_q[sz-1] = TailMarkLo ^ 8'($urandom_range(1, 255));
        else wire_q[sz-2] = TailMarkHi ^ 8'($urandom_range(1, 255));
      end
    end
    if (sz > ChkAt) begin
      s = '0;
      for (int i = 0; i < sz; i++) if (i != ChkAt) s = s + wire_q[i];
      wire_q[ChkAt] = sum_ok ? s : s + 8'($urandom_range(1, 255));
    end
  endfunction

  function automatic void check_field(input string name, input logic [47:0] want_v,
                                      input logic [47:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      fail_count++;
    end
  endfunction

  task automatic send_request(input operation_e op, input logic [7:0] b, input logic last,
                              input logic [7:0] idx, input bit typed_ok,
                              input verdict_e typed);
    int            gap;
    frame_result_t r;
    gap = sender_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      @(negedge clk_i) in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    operation_i <= op;
    rx_byte_i <= b;
    last_byte_i <= last;
    seq_index_i <= idx;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    if (judge_request(op, b, last, idx, r)) begin
      if (typed_ok) r.verdict = typed;
      pending_verdicts.push_back(r);
    end
    if (op == OP_BYTE) bytes_sent++;
  endtask

  task automatic send_read(input logic [7:0] idx, input bit typed_ok);
    send_request(OP_READ, 8'($urandom), 1'($urandom), idx, typed_ok, VERDICT_READ);
  endtask

  function automatic logic [7:0] pick_read_index();
    return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
  endfunction

  // Sends wire_q; with mix set, reads and full drains are slipped in between bytes.
  task automatic send_frame(input bit mix, input bit typed_ok, input verdict_e typed);
    int n;
    n = wire_q.size();
    for (int i = 0; i < n; i++) begin
      if (mix && $urandom_range(0, 99) == 0) send_read(pick_read_index(), 1'b0);
      if (mix && $urandom_range(0, 299) == 0) drain();
      send_request(OP_BYTE, wire_q[i], i == n - 1, 8'($urandom), typed_ok && i == n - 1,
                   typed);
    end
  endtask

  // Holds the sender back until every outstanding result has come out.
  task automatic drain();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic index, input logic [8:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (index == RegCheckMode) cur_mode = data[1:0];
    else cur_limit = data;
  endtask

  task automatic set_config(input logic [1:0] mode, input logic [8:0] limit);
    write_reg(RegCheckMode, {7'($urandom), mode});
    write_reg(RegSeqLimit, limit);
    @(negedge clk_i) cfg_we_i <= 1'b0;
  endtask

  task automatic run_probes();
    probe_row_t row;
    logic [15:0] flen;
    for (int k = 0; k < NumProbes; k++) begin
      row = ProbeRows[k];
      sender_calm = ($urandom_range(0, 3) == 0);
      if (row.mode != cur_mode || row.limit != cur_limit) begin
        drain();
        set_config(row.mode, row.limit);
      end
      if (row.is_read) begin
        send_request(OP_READ, 8'h00, 1'b0, row.idx, row.typed_ok, row.typed);
      end else begin
        flen = row.len_ok ? 16'(row.size) : 16'(row.size) ^ 16'h0100;
        build_frame(int'(row.size), row.ftype, flen, row.fid, row.tail_ok, row.sum_ok, 1'b0);
        send_frame(1'b0, row.typed_ok, row.typed);
      end
    end
  endtask

  task automatic run_random();
    int          start_bytes;
    int          frames_done;
    int          phase_left;
    int          kind;
    int          sz;
    int          pick;
    logic [8:0]  limit;
    logic [15:0] ftype;
    logic [15:0] flen;
    logic [31:0] fid;
    bit          tail_ok;
    bit          sum_ok;
    bit          raw;
    start_bytes = bytes_sent;
    frames_done = 0;
    phase_left = 0;
    while (bytes_sent - start_bytes < RandomBytes || frames_done < RandomFrames) begin
      if (phase_left == 0) begin
        drain();
        case ($urandom_range(0, 5))
          0: limit = 9'd1;
          1: limit = 9'd256;
          2: limit = 9'd511;
          3: limit = 9'd0;
          4: limit = 9'($urandom_range(2, 255));
          default: limit = 9'($urandom_range(257, 510));
        endcase
        set_config(2'($urandom_range(0, 3)), limit);
        phase_left = $urandom_range(6, 14);
      end
      sender_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 15)
        repeat ($urandom_range(1, 3)) send_read(pick_read_index(), 1'b0);
      if ($urandom_range(0, 99) < 5) drain();

      sz = $urandom_range(MinFrame, 100);
      if ($urandom_range(0, 39) == 0) sz = $urandom_range(101, MaxFrame);
      ftype = WantType;
      tail_ok = 1'b1;
      sum_ok = 1'b1;
      raw = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 60) fid = 32'($urandom_range(0, 15));
      else if (pick < 75) fid = 32'($urandom_range(0, 511));
      else if (pick < 88) fid = 32'(cur_limit) - 32'($urandom_range(0, 1));
      else fid = 32'($urandom);
      flen = 16'(sz);

      // Most frames are well formed; the rest carry one defect or are plain noise.
      kind = $urandom_range(0, 99);
      if (kind >= 70 && kind < 75) ftype = WantType ^ (16'h1 << $urandom_range(0, 15));
      else if (kind >= 75 && kind < 80) tail_ok = 1'b0;
      else if (kind >= 80 && kind < 85) flen = flen ^ (16'h1 << $urandom_range(0, 15));
      else if (kind >= 85 && kind < 90) sum_ok = 1'b0;
      else if (kind >= 90 && kind < 94) sz = $urandom_range(1, MinFrame - 1);
      else if (kind >= 94 && kind < 96) sz = $urandom_range(MaxFrame + 1, MaxFrame + 60);
      else if (kind >= 96) begin
        sz = $urandom_range(1, 80);
        raw = 1'b1;
      end
      build_frame(sz, ftype, flen, fid, tail_ok, sum_ok, raw);
      send_frame(1'b1, 1'b0, VERDICT_GOOD);
      frames_done++;
      phase_left--;
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = RegCheckMode;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    operation_i = OP_BYTE;
    rx_byte_i = '0;
    last_byte_i = 1'b0;
    seq_index_i = '0;
    reset_shadow();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    run_probes();
    run_random();
    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS test_frame_checker");
    end else begin
      $display("FAIL test_frame_checker");
    end
    $finish;
  end

  // Result side: stalls at random before each result, except during calm stretches.
  initial begin : result_sink
    int hold;
    int stretch;
    bit calm;
    out_stall_i = 1'b0;
    stretch = 0;
    calm = 1'b0;
    forever begin
      if (stretch == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        stretch = $urandom_range(8, 40);
      end
      stretch--;
      hold = calm ? 0 : $urandom_range(0, 15);
      if (hold > 0) begin
        @(negedge clk_i) out_stall_i <= 1'b1;
        repeat (hold - 1) @(negedge clk_i);
        @(negedge clk_i) out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      while (out_valid_o !== 1'b1) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : result_check
    frame_result_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_verdicts.size() == 0) begin
        $error("result with verdict %0d arrived with nothing outstanding", verdict_o);
        fail_count++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("verdict", 48'(want.verdict), 48'(verdict_o));
        check_field("frame_seq", 48'(want.frame_seq), 48'(frame_seq_o));
        check_field("frame_bytes", 48'(want.frame_bytes), 48'(frame_bytes_o));
        check_field("seq_hits", 48'(want.seq_hits), 48'(seq_hits_o));
        check_field("good_total", 48'(want.good_total), 48'(good_total_o));
        check_field("error_total", 48'(want.error_total), 48'(error_total_o));
        check_field("filtered_total", 48'(want.filtered_total), 48'(filtered_total_o));
        check_field("good_byte_total", want.good_byte_total, good_byte_total_o);
      end
    end
  end

  // Ends a hung run: counts cycles in which neither side moves a request.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
          (out_valid_o === 1'b1 && out_stall_i === 1'b0)) quiet = 0;
      else quiet++;
    end
    $display("FAIL test_frame_checker");
    $finish;
  end

endmodule
